FILE: hdl/psf_pkg.sv
package psf_pkg;

   localparam int COORD_BITS = 12;
   localparam int DIM_BITS   = 13;
   localparam int COUNT_BITS = 6;
   localparam int COLOR_BITS = 24;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;

   localparam logic [DIM_BITS-1:0]   DIM_MAX          = 13'd4096;
   localparam logic [DIM_BITS-1:0]   WIDTH_RESET      = 13'd640;
   localparam logic [DIM_BITS-1:0]   HEIGHT_RESET     = 13'd480;
   localparam logic [COUNT_BITS-1:0] VCOUNT_RESET     = 6'd3;
   localparam logic [COLOR_BITS-1:0] COLOR_RESET      = 24'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_COLOR   = 2'd3;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_RENDER = 1'b1;

   localparam logic KIND_INTERIOR = 1'b0;
   localparam logic KIND_EDGE     = 1'b1;

   typedef struct packed {
      logic load_wr;
      logic start;
      logic k_clr;
      logic k_inc;
      logic mm_step;
      logic ed_eval;
      logic mul;
      logic div_init;
      logic div_step;
      logic add;
      logic ins;
      logic cnt_clr;
      logic em_init;
      logic em_step;
      logic hz_step;
      logic mark;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic k_last;
      logic k_mm_last;
      logic in_range;
      logic y_in_frame;
      logic ev_skip;
      logic ev_vert;
      logic div_last;
      logic cnt_ge2;
      logic em_done;
      logic em_need_out;
      logic hz_need_out;
      logic out_free;
   } stat_type;

endpackage

FILE: hdl/psf_ctrl.sv
module psf_ctrl
   import psf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_type,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [16:0] {
      S_IDLE   = 17'b1 << 0,
      S_MM_RD  = 17'b1 << 1,
      S_MM_UP  = 17'b1 << 2,
      S_RANGE  = 17'b1 << 3,
      S_ED_RD  = 17'b1 << 4,
      S_ED_EV  = 17'b1 << 5,
      S_MUL    = 17'b1 << 6,
      S_DIV0   = 17'b1 << 7,
      S_DIV    = 17'b1 << 8,
      S_ADD    = 17'b1 << 9,
      S_INS    = 17'b1 << 10,
      S_CNT    = 17'b1 << 11,
      S_EM     = 17'b1 << 12,
      S_HZ_CHK = 17'b1 << 13,
      S_HZ_RD  = 17'b1 << 14,
      S_HZ_EV  = 17'b1 << 15,
      S_MARK   = 17'b1 << 16
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_type == REQ_LOAD) begin
               cmd.load_wr = 1'b1;
            end else if (accept) begin
               cmd.start = 1'b1;
               cmd.k_clr = 1'b1;
               state_in  = stat.n_zero ? S_HZ_CHK : S_MM_RD;
            end
         end
         S_MM_RD: state_in = S_MM_UP;
         S_MM_UP: begin
            cmd.mm_step = 1'b1;
            if (stat.k_mm_last) begin
               state_in = S_RANGE;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = S_MM_RD;
            end
         end
         S_RANGE: begin
            if (stat.in_range) begin
               cmd.k_clr   = 1'b1;
               cmd.cnt_clr = 1'b1;
               state_in    = S_ED_RD;
            end else begin
               state_in = S_HZ_CHK;
            end
         end
         S_ED_RD: state_in = S_ED_EV;
         S_ED_EV: begin
            cmd.ed_eval = 1'b1;
            if (stat.ev_skip) begin
               if (stat.k_last) begin
                  state_in = S_CNT;
               end else begin
                  cmd.k_inc = 1'b1;
                  state_in  = S_ED_RD;
               end
            end else if (stat.ev_vert) begin
               state_in = S_INS;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV0;
         end
         S_DIV0: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_INS;
         end
         S_INS: begin
            cmd.ins = 1'b1;
            if (stat.k_last) begin
               state_in = S_CNT;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = S_ED_RD;
            end
         end
         S_CNT: begin
            if (stat.cnt_ge2) begin
               cmd.em_init = 1'b1;
               state_in    = S_EM;
            end else begin
               state_in = S_HZ_CHK;
            end
         end
         S_EM: begin
            if (stat.em_done) begin
               state_in = S_HZ_CHK;
            end else if (!stat.em_need_out || stat.out_free) begin
               cmd.em_step = 1'b1;
            end
         end
         S_HZ_CHK: begin
            if (stat.y_in_frame && !stat.n_zero) begin
               cmd.k_clr = 1'b1;
               state_in  = S_HZ_RD;
            end else begin
               state_in = S_MARK;
            end
         end
         S_HZ_RD: state_in = S_HZ_EV;
         S_HZ_EV: begin
            if (!stat.hz_need_out || stat.out_free) begin
               cmd.hz_step = 1'b1;
               if (stat.k_last) begin
                  state_in = S_MARK;
               end else begin
                  cmd.k_inc = 1'b1;
                  state_in  = S_HZ_RD;
               end
            end
         end
         S_MARK: begin
            if (stat.out_free) begin
               cmd.mark = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: hdl/psf_dp.sv
module psf_dp
   import psf_pkg::*;
#(
   parameter int MAX_VERTICES = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic [4:0]            req_vertex_index,
   input  logic [COORD_BITS-1:0] req_vertex_x,
   input  logic [COORD_BITS-1:0] req_vertex_y,
   input  logic [COORD_BITS-1:0] req_scan_y,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_has_span,
   output logic                  rsp_span_kind,
   output logic [COORD_BITS-1:0] rsp_span_row,
   output logic [COORD_BITS-1:0] rsp_span_start,
   output logic [COORD_BITS-1:0] rsp_span_end,
   output logic [COLOR_BITS-1:0] rsp_span_color,
   output logic                  rsp_is_last
);

   localparam int CW = COORD_BITS;
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int KW = $clog2(MAX_VERTICES + 1);
   localparam int DW = $clog2(CW + 1);

   logic [DIM_BITS-1:0]   width_ff, height_ff;
   logic [COUNT_BITS-1:0] vcount_ff;
   logic [COLOR_BITS-1:0] color_ff;
   logic [DIM_BITS-1:0]   w_sat, h_sat, w_m1;
   logic [KW-1:0]         n_eff;

   logic [2*CW-1:0] vmem [MAX_VERTICES];
   logic [2*CW-1:0] rd_ff, prev_ff;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic            idx_ok;
   logic [CW-1:0]   rd_x, rd_y, px, py;

   logic [KW-1:0]   k_ff;
   logic [CW-1:0]   y_ff, top_ff, bot_ff;

   logic            swap, skip_y, vert, horiz;
   logic [CW-1:0]   xa, ya, xb, yb;
   logic [CW-1:0]   xa_ff, dx_ff, ady_ff, aoff_ff, cand_ff;
   logic [2*CW-1:0] prod_ff;
   logic [CW-1:0]   rem_ff, q_ff;
   logic [DW-1:0]   div_cnt_ff;
   logic [CW:0]     trial;
   logic            q_bit;

   logic [CW-1:0]   arr_ff [MAX_VERTICES];
   logic [CW-1:0]   arr_in [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] le;
   logic [KW-1:0]   cnt_ff, em_left_ff;
   logic [CW-1:0]   last_ff, start_ff, head;
   logic            have_last_ff, pend_ff, uniq;

   logic [DIM_BITS-1:0] hz_e13;
   logic [CW-1:0]       hz_end;

   logic                  rsp_valid_ff, has_ff, kind_ff, last_item_ff;
   logic [CW-1:0]         row_ff, s_ff, e_ff;
   logic [COLOR_BITS-1:0] col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         vcount_ff <= VCOUNT_RESET;
         color_ff  <= COLOR_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_wr_data[DIM_BITS-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_wr_data[DIM_BITS-1:0];
            CSR_VERTEX_COUNT: vcount_ff <= csr_wr_data[COUNT_BITS-1:0];
            CSR_FILL_COLOR:   color_ff  <= csr_wr_data[COLOR_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign w_sat = (width_ff == '0) ? DIM_BITS'(1) : (width_ff > DIM_MAX) ? DIM_MAX : width_ff;
   assign h_sat = (height_ff == '0) ? DIM_BITS'(1) :
                  (height_ff > DIM_MAX) ? DIM_MAX : height_ff;
   assign w_m1  = w_sat - DIM_BITS'(1);
   assign n_eff = (int'(vcount_ff) > MAX_VERTICES) ? KW'(MAX_VERTICES) : KW'(vcount_ff);

   assign idx_ok  = int'(req_vertex_index) < MAX_VERTICES;
   assign wr_addr = AW'(req_vertex_index);
   assign rd_addr = (k_ff == n_eff) ? '0 : k_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_wr && idx_ok) begin
         vmem[wr_addr] <= {req_vertex_x, req_vertex_y};
      end
      rd_ff <= vmem[rd_addr];
   end

   assign rd_x = rd_ff[2*CW-1:CW];
   assign rd_y = rd_ff[CW-1:0];
   assign px   = prev_ff[2*CW-1:CW];
   assign py   = prev_ff[CW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (cmd.k_clr) begin
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         y_ff   <= req_scan_y;
         top_ff <= CW'(h_sat - DIM_BITS'(1));
         bot_ff <= '0;
      end else if (cmd.mm_step) begin
         if (rd_y < top_ff) begin
            top_ff <= rd_y;
         end
         if (rd_y > bot_ff) begin
            bot_ff <= rd_y;
         end
      end
   end

   assign swap   = px > rd_x;
   assign xa     = swap ? rd_x : px;
   assign ya     = swap ? rd_y : py;
   assign xb     = swap ? px : rd_x;
   assign yb     = swap ? py : rd_y;
   assign skip_y = (py < y_ff && rd_y < y_ff) || (py > y_ff && rd_y > y_ff);
   assign vert   = (px == rd_x);
   assign horiz  = (py == rd_y);

   always_ff @(posedge clock) begin
      if (cmd.ed_eval) begin
         xa_ff   <= xa;
         dx_ff   <= xb - xa;
         ady_ff  <= (yb > ya) ? yb - ya : ya - yb;
         aoff_ff <= (y_ff > ya) ? y_ff - ya : ya - y_ff;
         cand_ff <= px;
      end else if (cmd.add) begin
         cand_ff <= xa_ff + q_ff;
      end
      if (cmd.ed_eval || cmd.hz_step) begin
         prev_ff <= rd_ff;
      end
      if (cmd.mul) begin
         prod_ff <= (2*CW)'(aoff_ff) * (2*CW)'(dx_ff);
      end
   end

   assign trial = {rem_ff, q_ff[CW-1]};
   assign q_bit = trial >= {1'b0, ady_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_init) begin
         div_cnt_ff <= DW'(CW);
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff - DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= prod_ff[2*CW-1:CW];
         q_ff   <= prod_ff[CW-1:0];
      end else if (cmd.div_step) begin
         rem_ff <= q_bit ? CW'(trial - {1'b0, ady_ff}) : trial[CW-1:0];
         q_ff   <= {q_ff[CW-2:0], q_bit};
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
         le[j] = (KW'(j) < cnt_ff) && (arr_ff[j] <= cand_ff);
      end
      arr_in[0] = le[0] ? arr_ff[0] : cand_ff;
      for (int j = 1; j < MAX_VERTICES; j++) begin
         if (le[j]) begin
            arr_in[j] = arr_ff[j];
         end else if (le[j-1]) begin
            arr_in[j] = cand_ff;
         end else begin
            arr_in[j] = arr_ff[j-1];
         end
      end
   end

   assign head = arr_ff[0];
   assign uniq = !have_last_ff || (head != last_ff);

   always_ff @(posedge clock) begin
      if (cmd.ins && ({1'b0, cand_ff} < w_sat)) begin
         for (int j = 0; j < MAX_VERTICES; j++) begin
            arr_ff[j] <= arr_in[j];
         end
      end else if (cmd.em_step) begin
         for (int j = 0; j < MAX_VERTICES - 1; j++) begin
            arr_ff[j] <= arr_ff[j+1];
         end
      end
      if (cmd.em_step) begin
         last_ff <= head;
         if (uniq && !pend_ff) begin
            start_ff <= head;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         em_left_ff   <= '0;
         have_last_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (cmd.cnt_clr) begin
            cnt_ff <= '0;
         end else if (cmd.ins && ({1'b0, cand_ff} < w_sat)) begin
            cnt_ff <= cnt_ff + KW'(1);
         end
         if (cmd.em_init) begin
            em_left_ff   <= cnt_ff;
            have_last_ff <= 1'b0;
            pend_ff      <= 1'b0;
         end else if (cmd.em_step) begin
            em_left_ff   <= em_left_ff - KW'(1);
            have_last_ff <= 1'b1;
            if (uniq) begin
               pend_ff <= !pend_ff;
            end
         end
      end
   end

   assign hz_e13 = {1'b0, xb} - DIM_BITS'(1);
   assign hz_end = (hz_e13 > w_m1) ? w_m1[CW-1:0] : hz_e13[CW-1:0];

   always_comb begin
      stat             = '0;
      stat.n_zero      = (n_eff == '0);
      stat.k_last      = (k_ff == n_eff);
      stat.k_mm_last   = (k_ff == n_eff - KW'(1));
      stat.in_range    = (y_ff >= top_ff) && (y_ff < bot_ff) && ({1'b0, y_ff} < h_sat);
      stat.y_in_frame  = ({1'b0, y_ff} < h_sat);
      stat.ev_skip     = (k_ff == '0) || skip_y || (!vert && horiz);
      stat.ev_vert     = vert;
      stat.div_last    = (div_cnt_ff == DW'(1));
      stat.cnt_ge2     = (cnt_ff >= KW'(2));
      stat.em_done     = (em_left_ff == '0);
      stat.em_need_out = uniq && pend_ff;
      stat.hz_need_out = (k_ff != '0) && horiz && (py == y_ff) && !vert &&
                         ({1'b0, xa} < w_sat);
      stat.out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.mark || (cmd.em_step && stat.em_need_out) ||
                   (cmd.hz_step && stat.hz_need_out)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mark) begin
         has_ff       <= 1'b0;
         kind_ff      <= KIND_INTERIOR;
         row_ff       <= y_ff;
         s_ff         <= '0;
         e_ff         <= '0;
         col_ff       <= '0;
         last_item_ff <= 1'b1;
      end else if (cmd.em_step && stat.em_need_out) begin
         has_ff       <= 1'b1;
         kind_ff      <= KIND_INTERIOR;
         row_ff       <= y_ff;
         s_ff         <= start_ff;
         e_ff         <= head;
         col_ff       <= color_ff;
         last_item_ff <= 1'b0;
      end else if (cmd.hz_step && stat.hz_need_out) begin
         has_ff       <= 1'b1;
         kind_ff      <= KIND_EDGE;
         row_ff       <= y_ff;
         s_ff         <= xa;
         e_ff         <= hz_end;
         col_ff       <= color_ff;
         last_item_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_has_span   = has_ff;
   assign rsp_span_kind  = kind_ff;
   assign rsp_span_row   = row_ff;
   assign rsp_span_start = s_ff;
   assign rsp_span_end   = e_ff;
   assign rsp_span_color = col_ff;
   assign rsp_is_last    = last_item_ff;

endmodule

FILE: hdl/polygon_scanline_span_fill_top.sv
// Channel   Direction  Handshake            Word
// req       in         req_valid/req_ready  vertex load or scanline render request
// rsp       out        rsp_valid/rsp_ready  span or closing marker
// csr       in         csr_wr_en            register write, no wait
//
// A load writes one vertex and leaves the block ready. A render walks the vertex memory
// (one read port) for the row's min/max, evaluates each edge with a shared restoring
// divider that works through the 12 quotient bits one at a time, inserts each crossing
// into a sorted list, pairs them into spans, walks horizontal edges and sends the marker.
// Reset is synchronous and clears control and CSR state; vertex memory is not cleared.
// A stalled rsp holds the controller at its emit step; req waits until the marker is issued.
module polygon_scanline_span_fill_top
   import psf_pkg::*;
#(
   parameter int MAX_VERTICES = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_type,
   input  logic [4:0]            req_vertex_index,
   input  logic [COORD_BITS-1:0] req_vertex_x,
   input  logic [COORD_BITS-1:0] req_vertex_y,
   input  logic [COORD_BITS-1:0] req_scan_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_has_span,
   output logic                  rsp_span_kind,
   output logic [COORD_BITS-1:0] rsp_span_row,
   output logic [COORD_BITS-1:0] rsp_span_start,
   output logic [COORD_BITS-1:0] rsp_span_end,
   output logic [COLOR_BITS-1:0] rsp_span_color,
   output logic                  rsp_is_last,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   psf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   psf_dp #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_vertex_index (req_vertex_index),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_scan_y       (req_scan_y),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_has_span     (rsp_has_span),
      .rsp_span_kind    (rsp_span_kind),
      .rsp_span_row     (rsp_span_row),
      .rsp_span_start   (rsp_span_start),
      .rsp_span_end     (rsp_span_end),
      .rsp_span_color   (rsp_span_color),
      .rsp_is_last      (rsp_is_last)
   );

   a_marker_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |-> !rsp_has_span)
      else $error("closing marker carries a span");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_span |-> rsp_span_start <= rsp_span_end)
      else $error("span start beyond span end");

   a_render_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_RENDER |=> !req_ready)
      else $error("request taken during render");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import psf_pkg::*;

   localparam int SLOTS      = 32;
   localparam int WDOG_LIMIT = 20000;

   typedef struct packed {
      logic                  has_span;
      logic                  span_kind;
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] first;
      logic [COORD_BITS-1:0] last_col;
      logic [COLOR_BITS-1:0] color;
      logic                  is_last;
   } span_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = REQ_LOAD;
   logic [4:0]            req_vertex_index = '0;
   logic [COORD_BITS-1:0] req_vertex_x = '0;
   logic [COORD_BITS-1:0] req_vertex_y = '0;
   logic [COORD_BITS-1:0] req_scan_y = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_has_span;
   logic                  rsp_span_kind;
   logic [COORD_BITS-1:0] rsp_span_row;
   logic [COORD_BITS-1:0] rsp_span_start;
   logic [COORD_BITS-1:0] rsp_span_end;
   logic [COLOR_BITS-1:0] rsp_span_color;
   logic                  rsp_is_last;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   polygon_scanline_span_fill_top DUT (.*);

   always #10 clock = ~clock;

   // shadow of the block state
   logic [COORD_BITS-1:0] poly_x [SLOTS];
   logic [COORD_BITS-1:0] poly_y [SLOTS];
   logic [DIM_BITS-1:0]   frame_w = WIDTH_RESET;
   logic [DIM_BITS-1:0]   frame_h = HEIGHT_RESET;
   logic [COUNT_BITS-1:0] vert_cnt = VCOUNT_RESET;
   logic [COLOR_BITS-1:0] fill_rgb = COLOR_RESET;

   span_word_type span_q [$];

   int  mismatches = 0;
   int  n_loads = 0, n_renders = 0, n_spans = 0, n_markers = 0;
   int  idle_cycles = 0;
   int  hold_off = 0;
   int  stall_left = 0;
   bit  req_gaps = 1'b1;
   bit  rsp_stalls = 1'b1;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      return $urandom_range(15, 50);
   endfunction

   function automatic int unsigned sat_dim(input logic [DIM_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > DIM_MAX) return DIM_MAX;
      return v;
   endfunction

   function automatic span_word_type make_span(input logic kind, input int unsigned row,
                                               input int unsigned s, input int unsigned e);
      span_word_type sw;
      sw.has_span  = 1'b1;
      sw.span_kind = kind;
      sw.row       = row[COORD_BITS-1:0];
      sw.first     = s[COORD_BITS-1:0];
      sw.last_col  = e[COORD_BITS-1:0];
      sw.color     = fill_rgb;
      sw.is_last   = 1'b0;
      return sw;
   endfunction

   task automatic predict_row_spans(input int unsigned y);
      int unsigned w, h, n, top, bottom, b, x0, y0, x1, y1, c, t, e, ncr, u, v, i, j;
      int unsigned xcol [SLOTS];
      span_word_type sw;
      w = sat_dim(frame_w);
      h = sat_dim(frame_h);
      n = (vert_cnt > SLOTS) ? SLOTS : vert_cnt;
      top = h - 1;
      bottom = 0;
      ncr = 0;
      for (i = 0; i < n; i++) begin
         if (poly_y[i] < top) top = poly_y[i];
         if (poly_y[i] > bottom) bottom = poly_y[i];
      end
      if (bottom > h) bottom = h;
      if (n > 0 && y >= top && y < bottom) begin
         for (i = 0; i < n; i++) begin
            b = (i + 1 < n) ? i + 1 : 0;
            x0 = poly_x[i]; y0 = poly_y[i];
            x1 = poly_x[b]; y1 = poly_y[b];
            if ((y0 < y && y1 < y) || (y0 > y && y1 > y)) continue;
            if (x0 == x1) begin
               c = x0;
            end else begin
               if (y0 == y1) continue;
               if (x0 > x1) begin
                  t = x0; x0 = x1; x1 = t;
                  t = y0; y0 = y1; y1 = t;
               end
               c = x0 + (((y > y0) ? y - y0 : y0 - y) * (x1 - x0))
                        / ((y1 > y0) ? y1 - y0 : y0 - y1);
            end
            if (c >= w) continue;
            xcol[ncr] = c;
            ncr++;
         end
         if (ncr >= 2) begin
            for (i = 1; i < ncr; i++) begin
               v = xcol[i];
               j = i;
               while (j > 0 && xcol[j-1] > v) begin
                  xcol[j] = xcol[j-1];
                  j--;
               end
               xcol[j] = v;
            end
            u = 0;
            for (i = 0; i < ncr; i++)
               if (u == 0 || xcol[u-1] != xcol[i]) begin
                  xcol[u] = xcol[i];
                  u++;
               end
            for (i = 0; i + 1 < u; i += 2)
               span_q.push_back(make_span(KIND_INTERIOR, y, xcol[i], xcol[i+1]));
         end
      end
      if (y < h) begin
         for (i = 0; i < n; i++) begin
            b = (i + 1 < n) ? i + 1 : 0;
            x0 = poly_x[i]; x1 = poly_x[b];
            if (poly_y[i] != poly_y[b] || poly_y[i] != y) continue;
            if (x0 > x1) begin
               t = x0; x0 = x1; x1 = t;
            end
            if (x0 == x1 || x0 >= w) continue;
            e = x1 - 1;
            if (e > w - 1) e = w - 1;
            span_q.push_back(make_span(KIND_EDGE, y, x0, e));
         end
      end
      sw = '0;
      sw.row = y[COORD_BITS-1:0];
      sw.is_last = 1'b1;
      span_q.push_back(sw);
   endtask

   // call at a rising edge; returns at the edge that accepts the word, or after a random gap that follows it
   task automatic send_word(input logic typ, input logic [4:0] idx,
                            input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input logic [COORD_BITS-1:0] sy);
      int gap;
      req_valid <= 1'b1;
      req_type <= typ;
      req_vertex_index <= idx;
      req_vertex_x <= x;
      req_vertex_y <= y;
      req_scan_y <= sy;
      do @(posedge clock); while (!req_ready);
      if (typ == REQ_LOAD) begin
         poly_x[idx] = x;
         poly_y[idx] = y;
         n_loads++;
      end else begin
         predict_row_spans(sy);
         n_renders++;
      end
      gap = (req_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_vertex(input int idx, input int x, input int y);
      send_word(REQ_LOAD, idx[4:0], x[COORD_BITS-1:0], y[COORD_BITS-1:0],
                COORD_BITS'($urandom_range(0, 4095)));
   endtask

   task automatic render_row(input int y);
      send_word(REQ_RENDER, 5'($urandom_range(0, 31)), COORD_BITS'($urandom_range(0, 4095)),
                COORD_BITS'($urandom_range(0, 4095)), y[COORD_BITS-1:0]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (span_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:  frame_w = data[DIM_BITS-1:0];
         CSR_FRAME_HEIGHT: frame_h = data[DIM_BITS-1:0];
         CSR_VERTEX_COUNT: vert_cnt = data[COUNT_BITS-1:0];
         default:          fill_rgb = data[COLOR_BITS-1:0];
      endcase
   endtask

   task automatic set_frame(input int unsigned w, input int unsigned h,
                            input int unsigned n, input int unsigned rgb);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_VERTEX_COUNT, n);
      write_reg(CSR_FILL_COLOR, rgb);
   endtask

   task automatic test_triangle_defaults();
      int i;
      for (i = 0; i < SLOTS; i++)
         load_vertex(i, $urandom_range(0, 4095), $urandom_range(0, 4095));
      load_vertex(31, 4095, 4095);
      load_vertex(0, 10, 5);
      load_vertex(1, 4095, 50);
      load_vertex(2, 0, 90);
      render_row(0);
      render_row(5);
      render_row(20);
      render_row(50);
      render_row(89);
      render_row(90);
      render_row(4095);
      drain();
   endtask

   task automatic test_horizontal_edges();
      set_frame(640, 480, 4, 24'hFFFFFF);
      load_vertex(0, 20, 10);
      load_vertex(1, 60, 10);
      load_vertex(2, 60, 40);
      load_vertex(3, 20, 40);
      render_row(9);
      render_row(10);
      render_row(25);
      render_row(40);
      render_row(41);
      drain();
      write_reg(CSR_FRAME_WIDTH, 50);
      render_row(10);
      render_row(25);
      drain();
      write_reg(CSR_FRAME_WIDTH, 20);
      render_row(10);
      render_row(40);
      drain();
   endtask

   task automatic test_register_extremes();
      set_frame(0, 0, 0, 24'h000000);
      render_row(0);
      render_row(1);
      drain();
      set_frame(4096, 4096, 1, 24'hA5A5A5);
      render_row(10);
      render_row(4095);
      drain();
      set_frame(8191, 8191, 63, 24'h5A5A5A);
      render_row(poly_y[7]);
      render_row(2048);
      drain();
      set_frame(4096, 1, 32, 24'hFFFFFF);
      render_row(0);
      drain();
   endtask

   // zigzag polygon: many crossings per row
   task automatic test_backpressure();
      int i;
      set_frame(4096, 4096, 32, 24'h123456);
      for (i = 0; i < 16; i++) begin
         load_vertex(i, 20 + i * 60, (i % 2) ? 400 : 100);
         load_vertex(31 - i, 20 + i * 60, (i % 2) ? 900 : 1200);
      end
      drain();
      req_gaps = 1'b0;
      hold_off = 400;
      for (i = 0; i < 8; i++) render_row($urandom_range(90, 1210));
      req_gaps = 1'b1;
      drain();
   endtask

   task automatic test_random_polygons(input int target);
      int done, n, w, h, lim, i, rows, y, k;
      done = 0;
      while (done < target) begin
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(16, 800);
         h = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(16, 600);
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(3, 12);
         set_frame(w, h, n, $urandom());
         req_gaps = $urandom_range(0, 3) != 0;
         rsp_stalls = $urandom_range(0, 3) != 0;
         lim = (w > 4096 || w == 0) ? 4095 : w;
         if (n > SLOTS) n = SLOTS;
         for (i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if (i > 0 && k == 0)
               load_vertex(i, poly_x[i-1], $urandom_range(0, lim));
            else if (i > 0 && k == 1)
               load_vertex(i, $urandom_range(0, lim + 40), poly_y[i-1]);
            else if (k == 2)
               load_vertex(i, $urandom_range(0, 4095), $urandom_range(0, 4095));
            else
               load_vertex(i, $urandom_range(0, lim + 20), $urandom_range(0, lim));
            done++;
         end
         rows = $urandom_range(6, 16);
         for (i = 0; i < rows; i++) begin
            k = $urandom_range(0, 9);
            if (k < 6 && n > 0)
               y = poly_y[$urandom_range(0, n - 1)] + $urandom_range(0, 60) - 30;
            else if (k < 9)
               y = $urandom_range(0, lim);
            else
               y = $urandom_range(0, 4095);
            if (y < 0) y = 0;
            if (y > 4095) y = 4095;
            if ($urandom_range(0, 9) == 0)
               load_vertex($urandom_range(0, 31), $urandom_range(0, 4095),
                           $urandom_range(0, 4095));
            render_row(y);
            done++;
         end
         drain();
      end
      req_gaps = 1'b1;
      rsp_stalls = 1'b1;
   endtask

   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off--;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (rsp_stalls && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      span_word_type got, want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got = {rsp_has_span, rsp_span_kind, rsp_span_row, rsp_span_start, rsp_span_end,
                rsp_span_color, rsp_is_last};
         if (got.has_span) n_spans++;
         else n_markers++;
         if (span_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: has=%0d kind=%0d row=%0d %0d..%0d rgb=%h last=%0d",
                        got.has_span, got.span_kind, got.row, got.first, got.last_col,
                        got.color, got.is_last);
         end else begin
            want = span_q.pop_front();
            if (got.has_span !== want.has_span || got.span_kind !== want.span_kind ||
                got.row !== want.row || got.first !== want.first ||
                got.last_col !== want.last_col || got.color !== want.color ||
                got.is_last !== want.is_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp has=%0d kind=%0d row=%0d %0d..%0d rgb=%h last=%0d | got has=%0d kind=%0d row=%0d %0d..%0d rgb=%h last=%0d",
                           want.has_span, want.span_kind, want.row, want.first,
                           want.last_col, want.color, want.is_last,
                           got.has_span, got.span_kind, got.row, got.first,
                           got.last_col, got.color, got.is_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid === 1'b1 && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_triangle_defaults();
      test_horizontal_edges();
      test_register_extremes();
      test_backpressure();
      test_random_polygons(165);
      repeat (50) @(posedge clock);
      $display("covered %0d vertex loads and %0d scanline renders", n_loads, n_renders);
      $display("checked %0d spans and %0d closing markers, %0d mismatches",
               n_spans, n_markers, mismatches);
      if (mismatches == 0 && span_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         if (span_q.size() != 0) $display("%0d expected words never arrived", span_q.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: polygon_scanline_span_fill_top.f
hdl/psf_pkg.sv
hdl/psf_ctrl.sv
hdl/psf_dp.sv
hdl/polygon_scanline_span_fill_top.sv
verif/tb.sv
